FILE: hw/rtl/force_error_deadband_controller_core_defines.svh
// Assertion macros used by the force error deadband controller RTL.
`ifndef FORCE_ERROR_DEADBAND_CONTROLLER_CORE_DEFINES_SVH
`define FORCE_ERROR_DEADBAND_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, clocked on i_clk and held off during reset.
`define FED_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, clocked on i_clk and held off during reset.
`define FED_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

FILE: hw/rtl/fed_pkg.sv
// Shared types and constants of the force error deadband controller.
`default_nettype none
package fed_pkg;

    localparam int unsigned WHEEL_W = 3;
    localparam int unsigned FORCE_W = 16;
    localparam int unsigned ERR_W   = 16;
    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned LIMIT_W = 15;
    localparam int unsigned DRIVE_W = 32;
    localparam int unsigned NUM_W   = FORCE_W + 1 + 12;  // (ref - meas) * 4096
    localparam int unsigned QUOT_W  = ERR_W + 1;         // quotient magnitude before clamp

    localparam logic       CFG_FORCE_GAIN     = 1'b0;
    localparam logic       CFG_DEADBAND_LIMIT = 1'b1;
    localparam logic [1:0] SIGN_NONE   = 2'd0;
    localparam logic [1:0] SIGN_POS    = 2'd1;
    localparam logic [1:0] SIGN_NONPOS = 2'd2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd410;  // about 0.10 in Q3.12

    typedef struct packed {
        logic                      upd;
        logic                      enable;
        logic [WHEEL_W-1:0]        wheel;
        logic signed [ERR_W-1:0]   err;
    } t_db_cmd;

    typedef struct packed {
        logic                      done;
        logic signed [ERR_W-1:0]   quot;
    } t_div_res;

endpackage
`default_nettype wire

FILE: hw/rtl/force_error_deadband_controller_core.sv
// Force error deadband controller: one item at a time, one result per item. The relative
// error (ref - meas) / ref in Q3.12 comes from a bit-serial divider that retires one quotient
// bit per cycle. An item is taken, divided, gated by the deadband decision into the error
// register, multiplied by the gain and then loaded into the result register; a zero
// reference skips the divider and the multiply. The result register is loaded only when the
// output is free, and the input is ready only while the sequencer is idle; a finished result
// waits in the output register while the next item is taken and computed.
`default_nettype none
`include "force_error_deadband_controller_core_defines.svh"
module force_error_deadband_controller_core #(
    parameter int unsigned WHEELS = 6
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // Input items.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [2:0] wheel_index, [18:3] measured_force, [34:19] reference_force,
    // [35] deadband_enable, [39:36] zero
    input  wire logic [39:0] s_axis_tdata,
    // Result items.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [31:0] drive, [32] zero_reference, [39:33] zero
    output logic [39:0]      m_axis_tdata
);
    import fed_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] r_state, n_state;

    logic signed [GAIN_W-1:0]  r_gain;
    logic [LIMIT_W-1:0]        r_limit;

    logic [WHEEL_W-1:0]        r_wheel;
    logic                      r_enable;
    logic                      r_zero_ref;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [DRIVE_W-1:0] r_prod;
    logic                      r_m_valid;
    logic [39:0]               r_m_data;

    logic                      accept;
    logic [WHEEL_W-1:0]        in_wheel;
    logic signed [FORCE_W-1:0] in_meas;
    logic signed [FORCE_W-1:0] in_ref;
    logic                      in_enable;
    logic signed [FORCE_W:0]   diff;
    logic signed [NUM_W-1:0]   num;
    logic                      div_start;
    logic                      out_free;
    logic signed [ERR_W-1:0]   err_used;
    logic signed [DRIVE_W-1:0] prod;
    logic signed [DRIVE_W-1:0] drive;
    t_div_res                  div_res;
    t_db_cmd                   db_cmd;

    assign in_wheel  = s_axis_tdata[2:0];
    assign in_meas   = s_axis_tdata[18:3];
    assign in_ref    = s_axis_tdata[34:19];
    assign in_enable = s_axis_tdata[35];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign diff          = (FORCE_W+1)'(in_ref) - (FORCE_W+1)'(in_meas);
    assign num           = {diff, 12'd0};
    assign div_start     = accept && (in_ref != '0);
    assign out_free      = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= '0;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FORCE_GAIN:     r_gain  <= i_cfg_data;
                CFG_DEADBAND_LIMIT: r_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    fed_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (in_ref),
        .o_res   (div_res)
    );

    always_comb begin
        db_cmd.upd    = (r_state == ST_DIV) && div_res.done;
        db_cmd.enable = r_enable;
        db_cmd.wheel  = r_wheel;
        db_cmd.err    = div_res.quot;
    end

    fed_deadband #(.WHEELS(WHEELS)) u_deadband (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (db_cmd),
        .i_limit (r_limit),
        .o_err   (err_used)
    );

    // Q3.12 times Q8.8 stays within +-2^30, so the negation cannot leave 32 bits.
    assign prod  = DRIVE_W'(r_err) * DRIVE_W'(r_gain);
    assign drive = -r_prod;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (accept)       n_state = (in_ref == '0) ? ST_OUT : ST_DIV;
            ST_DIV:  if (div_res.done) n_state = ST_MUL;
            ST_MUL:                    n_state = ST_OUT;
            ST_OUT:  if (out_free)     n_state = ST_IDLE;
            default:                   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && out_free) r_m_valid <= 1'b1;
            else if (m_axis_tready)            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_wheel    <= in_wheel;
            r_enable   <= in_enable;
            r_zero_ref <= (in_ref == '0);
            r_prod     <= '0;
        end
        if (r_state == ST_DIV && div_res.done) r_err <= err_used;
        if (r_state == ST_MUL) r_prod <= prod;
        if (r_state == ST_OUT && out_free) begin
            r_m_data <= {7'd0, r_zero_ref, r_zero_ref ? DRIVE_W'(0) : drive};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    `FED_ASSERT_NEXT(a_busy_after_accept, accept, !s_axis_tready)
    `FED_ASSERT_NEXT(a_zero_ref_skips_div, accept && (in_ref == '0), r_state == ST_OUT)
    `FED_ASSERT_NEXT(a_div_then_mul, (r_state == ST_DIV) && div_res.done, r_state == ST_MUL)
    `FED_ASSERT_NOW(a_zero_ref_drive, m_axis_tvalid && m_axis_tdata[32], m_axis_tdata[31:0] == '0)

endmodule
`default_nettype wire

FILE: hw/rtl/fed_divider.sv
// Bit-serial restoring divider giving the saturated Q3.12 relative error.
`default_nettype none
module fed_divider (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic signed [fed_pkg::NUM_W-1:0]   i_num,
    input  wire logic signed [fed_pkg::FORCE_W-1:0] i_den,
    output fed_pkg::t_div_res                       o_res
);
    import fed_pkg::*;

    localparam int unsigned LO_W  = QUOT_W;            // dividend bits shifted in
    localparam int unsigned CNT_W = $clog2(LO_W);

    logic [NUM_W-1:0]   num_abs;
    logic [FORCE_W:0]   den_abs;
    logic [FORCE_W-1:0] den_mag;
    logic [FORCE_W:0]   trial;
    logic               ge;

    logic [FORCE_W-1:0] r_rem, n_rem;
    logic [FORCE_W-1:0] r_den;
    logic [LO_W-1:0]    r_lo, n_lo;
    logic [QUOT_W-1:0]  r_q, n_q;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic               r_ovf;
    logic               r_neg;
    logic signed [ERR_W-1:0] quot;

    assign num_abs = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign den_abs = i_den[FORCE_W-1] ? (FORCE_W+1)'(-$signed({i_den[FORCE_W-1], i_den}))
                                      : {1'b0, i_den};
    assign den_mag = den_abs[FORCE_W-1:0];  // 32768 still fits unsigned

    assign trial = {r_rem, r_lo[LO_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_comb begin
        n_rem = ge ? FORCE_W'(trial - {1'b0, r_den}) : trial[FORCE_W-1:0];
        n_lo  = {r_lo[LO_W-2:0], 1'b0};
        n_q   = {r_q[QUOT_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(LO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= den_mag;
            r_rem <= FORCE_W'(num_abs[NUM_W-2:LO_W]);
            r_lo  <= num_abs[LO_W-1:0];
            r_q   <= '0;
            // The quotient needs more than QUOT_W bits exactly when the top bits reach d.
            r_ovf <= FORCE_W'(num_abs[NUM_W-2:LO_W]) >= den_mag;
            r_neg <= i_num[NUM_W-1] ^ i_den[FORCE_W-1];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_lo  <= n_lo;
            r_q   <= n_q;
        end
    end

    always_comb begin
        if (r_neg) begin
            if (r_ovf || r_q > QUOT_W'(32768)) quot = -16'sd32768;
            else                               quot = ERR_W'(-r_q);
        end else begin
            if (r_ovf || r_q > QUOT_W'(32767)) quot = 16'sd32767;
            else                               quot = ERR_W'(r_q);
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = quot;

endmodule
`default_nettype wire

FILE: hw/rtl/fed_deadband.sv
// Per-wheel hysteresis deadband state and error gating.
`default_nettype none
module fed_deadband #(
    parameter int unsigned WHEELS = 6
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire fed_pkg::t_db_cmd                   i_cmd,
    input  wire logic [fed_pkg::LIMIT_W-1:0]        i_limit,
    output logic signed [fed_pkg::ERR_W-1:0]        o_err
);
    import fed_pkg::*;

    localparam int unsigned IDX_W = (WHEELS > 1) ? $clog2(WHEELS) : 1;

    logic [1:0]       r_sign     [WHEELS];
    logic             r_inactive [WHEELS];
    logic [IDX_W-1:0] idx;
    logic             apply;
    logic [1:0]       sgn;
    logic [ERR_W:0]   mag;
    logic             n_inactive;

    assign apply = i_cmd.enable && (32'(i_cmd.wheel) < WHEELS);
    assign idx   = IDX_W'(i_cmd.wheel);
    assign sgn   = (i_cmd.err > 0) ? SIGN_POS : SIGN_NONPOS;
    assign mag   = i_cmd.err[ERR_W-1] ? (ERR_W+1)'(-$signed({i_cmd.err[ERR_W-1], i_cmd.err}))
                                      : {1'b0, i_cmd.err};

    always_comb begin
        o_err      = i_cmd.err;
        n_inactive = 1'b0;
        if (apply) begin
            if (!r_inactive[idx]) begin
                // Active deadband: suppress, leave once the error is large.
                o_err      = '0;
                n_inactive = mag > (ERR_W+1)'(i_limit);
            end else begin
                // Passing: rearm the deadband when the error changes sign.
                n_inactive = (r_sign[idx] == sgn);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WHEELS; i++) begin
                r_sign[i]     <= SIGN_NONE;
                r_inactive[i] <= 1'b0;
            end
        end else if (i_cmd.upd && apply) begin
            r_sign[idx]     <= sgn;
            r_inactive[idx] <= n_inactive;
        end
    end

endmodule
`default_nettype wire

FILE: tb/sv/force_error_deadband_controller_core_tb.sv
// Self-checking testbench of the force error deadband controller core.
`default_nettype none
module force_error_deadband_controller_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fed_pkg::*;

    localparam int unsigned NUM_WHEELS    = 6;
    localparam int unsigned SETTLE_CYCLES = 30;
    localparam int unsigned STALL_LIMIT   = 3000;
    localparam int unsigned PHASE_ITEMS   = 360;

    typedef struct packed {
        logic               db_enable;
        logic signed [15:0] reference;
        logic signed [15:0] measured;
        logic [2:0]         wheel;
    } t_force_sample;

    typedef struct {
        logic signed [31:0] drive;
        logic               zero_ref;
    } t_drive_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_FORCE_GAIN;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    // Predictor copy of the registers and the per-wheel deadband state.
    logic signed [15:0] gain_q88;
    logic [14:0]        band_limit;
    logic [1:0]         last_sign [NUM_WHEELS];
    logic               band_open [NUM_WHEELS];

    t_drive_result pending_results [$];
    int fail_count;
    int idle_cycles;
    int hold_request;
    int sink_hold_left;
    int sink_stall_left;
    int sink_steady_left;
    int src_steady_left;

    force_error_deadband_controller_core #(
        .WHEELS(NUM_WHEELS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic t_drive_result predict_drive(input t_force_sample s);
        longint num;
        longint quot;
        longint mag;
        longint prod;
        logic [1:0] sgn;
        t_drive_result r;
        r.drive = '0;
        r.zero_ref = 1'b0;
        if (s.reference == 0) begin
            r.zero_ref = 1'b1;
            return r;
        end
        num = (longint'(s.reference) - longint'(s.measured)) * 4096;
        quot = num / longint'(s.reference);
        if (quot > 32767) quot = 32767;
        if (quot < -32768) quot = -32768;
        if (s.db_enable && s.wheel < NUM_WHEELS) begin
            sgn = (quot > 0) ? SIGN_POS : SIGN_NONPOS;
            mag = (quot < 0) ? -quot : quot;
            if (!band_open[s.wheel]) begin
                // While the deadband holds, the error is suppressed.
                if (mag > longint'(band_limit)) band_open[s.wheel] = 1'b1;
                quot = 0;
            end else if (last_sign[s.wheel] != sgn) begin
                band_open[s.wheel] = 1'b0;
            end
            last_sign[s.wheel] = sgn;
        end
        prod = -(quot * longint'(gain_q88));
        if (prod > 64'sd2147483647) prod = 64'sd2147483647;
        if (prod < -64'sd2147483648) prod = -64'sd2147483648;
        r.drive = prod[31:0];
        return r;
    endfunction

    function automatic t_force_sample make_sample(input int wheel, input int meas,
                                                  input int refv, input bit en);
        t_force_sample s;
        s.wheel = wheel[2:0];
        s.measured = meas[15:0];
        s.reference = refv[15:0];
        s.db_enable = en;
        return s;
    endfunction

    function automatic t_force_sample random_sample();
        int refv;
        int meas;
        int span;
        int wheel;
        bit en;
        wheel = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
        en = ($urandom_range(0, 4) != 0);
        refv = $signed(16'($urandom));
        meas = $signed(16'($urandom));
        case ($urandom_range(0, 9))
            0: ;
            1: refv = 0;
            2: refv = $urandom_range(0, 1) ? $urandom_range(1, 8) : -$urandom_range(1, 8);
            default: begin
                // Measurements near the reference keep the error around the deadband.
                if (refv == 0) refv = 1;
                span = ((refv < 0) ? -refv : refv) / 4 + 1;
                meas = refv + $urandom_range(0, 2 * span) - span;
                if (meas > 32767) meas = 32767;
                if (meas < -32768) meas = -32768;
            end
        endcase
        return make_sample(wheel, meas, refv, en);
    endfunction

    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_item(input t_force_sample s, input int gap);
        s_axis_tdata <= {4'b0, s};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(predict_drive(s));
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_random_item();
        int gap;
        if (src_steady_left > 0) begin
            src_steady_left--;
            gap = 0;
        end else if ($urandom_range(0, 39) == 0) begin
            src_steady_left = $urandom_range(20, 80);
            gap = 0;
        end else begin
            gap = idle_length();
        end
        send_item(random_sample(), gap);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic index, input logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        if (index == CFG_FORCE_GAIN) gain_q88 = data;
        else band_limit = data[14:0];
    endtask

    task automatic test_reset_defaults();
        send_item(make_sample(0, 100, 1000, 1'b0), 0);
        send_item(make_sample(1, 0, 5000, 1'b1), 2);
        wait_drained();
        write_reg(CFG_FORCE_GAIN, 16'h0100);
    endtask

    // Wheel 2 walks through both deadband states with the default limit.
    task automatic test_deadband_hysteresis();
        send_item(make_sample(2, 3686, 4096, 1'b1), 0);
        send_item(make_sample(2, 3685, 4096, 1'b1), 1);
        send_item(make_sample(2, 4000, 4096, 1'b1), 0);
        send_item(make_sample(2, 4200, 4096, 1'b1), 3);
        send_item(make_sample(2, 4096, 4096, 1'b1), 0);
        send_item(make_sample(2, 3000, 4096, 1'b0), 0);
    endtask

    task automatic test_zero_reference();
        send_item(make_sample(3, -32768, 0, 1'b1), 0);
        send_item(make_sample(7, 32767, 0, 1'b0), 1);
    endtask

    task automatic test_quotient_extremes();
        send_item(make_sample(0, -32768, 32767, 1'b0), 0);
        send_item(make_sample(0, 32767, -32768, 1'b0), 0);
        send_item(make_sample(0, 32767, -1, 1'b0), 0);
        send_item(make_sample(0, -32768, 1, 1'b0), 0);
        send_item(make_sample(0, 32767, 1, 1'b0), 0);
        send_item(make_sample(0, 4, 3, 1'b0), 0);
        send_item(make_sample(0, -4, -3, 1'b0), 0);
        send_item(make_sample(0, 1234, 1234, 1'b0), 0);
        wait_drained();
        write_reg(CFG_FORCE_GAIN, 16'h8000);
        send_item(make_sample(0, -32768, 1, 1'b0), 0);
        wait_drained();
        write_reg(CFG_FORCE_GAIN, 16'h7FFF);
        send_item(make_sample(0, 32767, 1, 1'b0), 0);
    endtask

    task automatic test_wheel_range();
        send_item(make_sample(6, 0, 100, 1'b1), 0);
        send_item(make_sample(7, 200, 100, 1'b1), 0);
        wait_drained();
    endtask

    task automatic test_random_settings();
        logic [15:0] gains  [5];
        logic [15:0] limits [5];
        gains = '{16'h0100, 16'h8000, 16'h7FFF, 16'($urandom), 16'($urandom)};
        limits = '{16'd0, 16'h7FFF, 16'd410, 16'($urandom_range(0, 32767)),
                   16'($urandom_range(0, 1500))};
        for (int p = 0; p < 5; p++) begin
            write_reg(CFG_FORCE_GAIN, gains[p]);
            write_reg(CFG_DEADBAND_LIMIT, limits[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) send_random_item();
            wait_drained();
        end
    endtask

    // The receiver holds off long enough for the block to stall its input.
    task automatic test_output_backpressure();
        write_reg(CFG_FORCE_GAIN, 16'($urandom));
        write_reg(CFG_DEADBAND_LIMIT, 16'($urandom_range(100, 2000)));
        hold_request = 400;
        for (int n = 0; n < 40; n++) send_item(random_sample(), 0);
    endtask

    task automatic test_drain_pause();
        wait_drained();
        for (int n = 0; n < 100; n++) send_random_item();
        wait_drained();
    endtask

    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            sink_hold_left = hold_request;
            hold_request = 0;
        end
        if (sink_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            sink_hold_left--;
        end else if (sink_stall_left > 0) begin
            m_axis_tready <= 1'b0;
            sink_stall_left--;
        end else if (sink_steady_left > 0) begin
            m_axis_tready <= 1'b1;
            sink_steady_left--;
        end else if ($urandom_range(0, 19) == 0) begin
            m_axis_tready <= 1'b1;
            sink_steady_left = $urandom_range(30, 150);
        end else if ($urandom_range(0, 2) == 0) begin
            m_axis_tready <= 1'b0;
            sink_stall_left = idle_length();
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_drive_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item, tdata %h", m_axis_tdata);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if ($signed(m_axis_tdata[31:0]) != exp_r.drive) begin
                    $error("drive: expected %0d, actual %0d", exp_r.drive,
                           $signed(m_axis_tdata[31:0]));
                    fail_count++;
                end
                if (m_axis_tdata[32] != exp_r.zero_ref) begin
                    $error("zero_reference: expected %0d, actual %0d", exp_r.zero_ref,
                           m_axis_tdata[32]);
                    fail_count++;
                end
                if (m_axis_tdata[39:33] != '0) begin
                    $error("padding: expected 0, actual %0h", m_axis_tdata[39:33]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        fail_count = 0;
        idle_cycles = 0;
        hold_request = 0;
        sink_hold_left = 0;
        sink_stall_left = 0;
        sink_steady_left = 0;
        src_steady_left = 0;
        gain_q88 = '0;
        band_limit = LIMIT_RESET;
        for (int w = 0; w < NUM_WHEELS; w++) begin
            last_sign[w] = SIGN_NONE;
            band_open[w] = 1'b0;
        end
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_deadband_hysteresis();
        test_zero_reference();
        test_quotient_extremes();
        test_wheel_range();
        test_random_settings();
        test_output_backpressure();
        test_drain_pause();

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
